// File: hw/rtl/lgmr_pkg.sv
package lgmr_pkg;

    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 26;
    localparam int TOTAL_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // 1.0 in 8 fraction bits
    localparam logic signed [WEIGHT_W+1:0] ONE_FIXED = 18'sd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ABS   = 2'd2;

    // gap classes
    localparam logic [1:0] CLASS_FINITE    = 2'd0;
    localparam logic [1:0] CLASS_PLUS_INF  = 2'd1;
    localparam logic [1:0] CLASS_MINUS_INF = 2'd2;

    typedef enum logic [1:0] {
        MODE_BINARY  = 2'd0,
        MODE_HAMMING = 2'd1,
        MODE_PRIOR   = 2'd2,
        MODE_WDIFF   = 2'd3
    } t_gap_mode;

    typedef enum logic {
        AGG_MIN = 1'b0,
        AGG_SUM = 1'b1
    } t_agg_mode;

    typedef struct packed {
        logic                fire;
        logic                elem;
        logic                fault;
        logic                corr;
        logic [WEIGHT_W-1:0] weight;
        logic                end_vec;
        logic                end_clu;
        logic                end_shot;
    } t_step;

    typedef struct packed {
        logic                      seen;
        logic signed [SCORE_W-1:0] minimum;
    } t_clu;

endpackage

// File: hw/rtl/lgmr_vec.sv
module lgmr_vec (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lgmr_pkg::t_step                   i_step,
    input  lgmr_pkg::t_gap_mode               i_gap_mode,
    input  logic                              i_use_abs,
    output lgmr_pkg::t_clu                    o_clu,
    output logic [lgmr_pkg::COUNT_W-1:0]      o_count
);

    logic signed [lgmr_pkg::SCORE_W-1:0] r_score, n_score;
    logic signed [lgmr_pkg::SCORE_W-1:0] r_min, n_min;
    logic                                r_seen, n_seen;
    logic [lgmr_pkg::COUNT_W-1:0]        r_count, n_count;

    logic signed [lgmr_pkg::WEIGHT_W+1:0] addend;
    logic signed [lgmr_pkg::SCORE_W:0]    sum;
    logic signed [lgmr_pkg::SCORE_W-1:0]  sum_sat;
    logic signed [lgmr_pkg::SCORE_W:0]    neg;
    logic signed [lgmr_pkg::SCORE_W-1:0]  vec_final;
    logic                                 close_v;

    always_comb begin
        addend = '0;
        if (i_step.fault) begin
            unique case (i_gap_mode)
                lgmr_pkg::MODE_BINARY:  addend = '0;
                lgmr_pkg::MODE_HAMMING: addend = lgmr_pkg::ONE_FIXED;
                lgmr_pkg::MODE_PRIOR:   addend = $signed({2'b00, i_step.weight});
                lgmr_pkg::MODE_WDIFF:   addend = i_step.corr ? -$signed({2'b00, i_step.weight})
                                                            : $signed({2'b00, i_step.weight});
                default:                addend = '0;
            endcase
        end
    end

    always_comb begin
        sum = {r_score[lgmr_pkg::SCORE_W-1], r_score}
            + (lgmr_pkg::SCORE_W+1)'(addend);
        // overflow when the top two bits disagree
        if (sum[lgmr_pkg::SCORE_W] != sum[lgmr_pkg::SCORE_W-1]) begin
            sum_sat = sum[lgmr_pkg::SCORE_W] ? lgmr_pkg::SCORE_MIN : lgmr_pkg::SCORE_MAX;
        end else begin
            sum_sat = sum[lgmr_pkg::SCORE_W-1:0];
        end

        neg = -{sum_sat[lgmr_pkg::SCORE_W-1], sum_sat};
        vec_final = sum_sat;
        if (i_gap_mode == lgmr_pkg::MODE_WDIFF && i_use_abs && sum_sat[lgmr_pkg::SCORE_W-1]) begin
            // negating the most negative score saturates
            if (neg[lgmr_pkg::SCORE_W] != neg[lgmr_pkg::SCORE_W-1]) begin
                vec_final = lgmr_pkg::SCORE_MAX;
            end else begin
                vec_final = neg[lgmr_pkg::SCORE_W-1:0];
            end
        end

        close_v = i_step.elem && (i_step.end_vec || i_step.end_clu || i_step.end_shot);

        o_clu.seen    = r_seen || close_v;
        o_clu.minimum = r_min;
        if (close_v && (!r_seen || vec_final < r_min)) begin
            o_clu.minimum = vec_final;
        end

        o_count = r_count;
        if (close_v && r_count != lgmr_pkg::COUNT_MAX) begin
            o_count = r_count + 1'b1;
        end
    end

    always_comb begin
        n_score = r_score;
        n_min   = r_min;
        n_seen  = r_seen;
        n_count = r_count;
        if (i_step.fire) begin
            if (i_step.end_shot) begin
                n_score = '0;
                n_min   = '0;
                n_seen  = 1'b0;
                n_count = '0;
            end else begin
                if (close_v) begin
                    n_score = '0;
                end else if (i_step.elem) begin
                    n_score = sum_sat;
                end
                if (i_step.end_clu) begin
                    n_min  = '0;
                    n_seen = 1'b0;
                end else begin
                    n_min  = o_clu.minimum;
                    n_seen = o_clu.seen;
                end
                n_count = o_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
            r_min   <= '0;
            r_seen  <= 1'b0;
            r_count <= '0;
        end else begin
            r_score <= n_score;
            r_min   <= n_min;
            r_seen  <= n_seen;
            r_count <= n_count;
        end
    end

endmodule

// File: hw/rtl/lgmr_shot.sv
module lgmr_shot (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lgmr_pkg::t_step                    i_step,
    input  lgmr_pkg::t_clu                     i_clu,
    input  logic [lgmr_pkg::COUNT_W-1:0]       i_count,
    input  lgmr_pkg::t_gap_mode                i_gap_mode,
    input  lgmr_pkg::t_agg_mode                i_agg_mode,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic signed [lgmr_pkg::TOTAL_W-1:0] o_gap,
    output logic [1:0]                         o_gap_class,
    output logic [lgmr_pkg::COUNT_W-1:0]       o_vector_count
);

    logic signed [lgmr_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                                r_seen, n_seen;
    logic                                r_out_vld;
    logic signed [lgmr_pkg::TOTAL_W-1:0] r_gap, gap_val;
    logic [1:0]                          r_class, class_val;
    logic [lgmr_pkg::COUNT_W-1:0]        r_out_count;

    logic signed [lgmr_pkg::TOTAL_W-1:0] clu_ext;
    logic signed [lgmr_pkg::TOTAL_W:0]   sum;
    logic signed [lgmr_pkg::TOTAL_W-1:0] total_after;
    logic                                seen_after;
    logic                                close_c;
    logic                                load;

    always_comb begin
        clu_ext = lgmr_pkg::TOTAL_W'(i_clu.minimum);
        sum     = {r_total[lgmr_pkg::TOTAL_W-1], r_total} + (lgmr_pkg::TOTAL_W+1)'(clu_ext);
        close_c = i_step.end_clu || i_step.end_shot;

        total_after = r_total;
        if (close_c && i_clu.seen) begin
            if (!r_seen) begin
                total_after = clu_ext;
            end else if (i_agg_mode == lgmr_pkg::AGG_MIN) begin
                total_after = (clu_ext < r_total) ? clu_ext : r_total;
            end else if (sum[lgmr_pkg::TOTAL_W] != sum[lgmr_pkg::TOTAL_W-1]) begin
                total_after = sum[lgmr_pkg::TOTAL_W] ? lgmr_pkg::TOTAL_MIN : lgmr_pkg::TOTAL_MAX;
            end else begin
                total_after = sum[lgmr_pkg::TOTAL_W-1:0];
            end
        end
        seen_after = r_seen || (close_c && i_clu.seen);

        gap_val = '0;
        if (i_gap_mode == lgmr_pkg::MODE_BINARY) begin
            class_val = seen_after ? lgmr_pkg::CLASS_MINUS_INF : lgmr_pkg::CLASS_PLUS_INF;
        end else if (!seen_after) begin
            class_val = lgmr_pkg::CLASS_PLUS_INF;
        end else begin
            class_val = lgmr_pkg::CLASS_FINITE;
            gap_val   = total_after;
        end

        load = i_step.fire && i_step.end_shot;

        n_total = r_total;
        n_seen  = r_seen;
        if (i_step.fire) begin
            n_total = i_step.end_shot ? '0 : total_after;
            n_seen  = i_step.end_shot ? 1'b0 : seen_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_seen    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_total <= n_total;
            r_seen  <= n_seen;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_gap       <= gap_val;
            r_class     <= class_val;
            r_out_count <= i_count;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_gap          = r_gap;
    assign o_gap_class    = r_class;
    assign o_vector_count = r_out_count;

endmodule

// File: hw/rtl/logical_gap_metric_reducer.sv
// a shot-closing transaction enters the input register when it is accepted, and its result
// is then captured in the result register, which drives the outputs
// throughput: one element transaction per cycle; a shot end waits only while the result
// register is full and stalled
// reset (i_rst_n low, synchronous) clears the accumulators, the configuration and both
// valid flags
module logical_gap_metric_reducer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lgmr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lgmr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_element_valid,
    input  logic                                 i_fault_bit,
    input  logic                                 i_correction_bit,
    input  logic [lgmr_pkg::WEIGHT_W-1:0]        i_weight,
    input  logic                                 i_last_in_vector,
    input  logic                                 i_last_in_cluster,
    input  logic                                 i_last_in_shot,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [lgmr_pkg::TOTAL_W-1:0]  o_gap,
    output logic [1:0]                           o_gap_class,
    output logic [lgmr_pkg::COUNT_W-1:0]         o_vector_count
);

    lgmr_pkg::t_gap_mode r_gap_mode;
    lgmr_pkg::t_agg_mode r_agg_mode;
    logic                r_use_abs;

    logic                r_in_vld;
    lgmr_pkg::t_step     r_in;
    lgmr_pkg::t_step     step;
    lgmr_pkg::t_clu      clu;
    logic [lgmr_pkg::COUNT_W-1:0] count;

    logic out_free;
    logic advance;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_mode <= lgmr_pkg::MODE_BINARY;
            r_agg_mode <= lgmr_pkg::AGG_MIN;
            r_use_abs  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lgmr_pkg::CFG_GAP_MODE: r_gap_mode <= lgmr_pkg::t_gap_mode'(i_cfg_wdata);
                lgmr_pkg::CFG_AGG_MODE: r_agg_mode <= lgmr_pkg::t_agg_mode'(i_cfg_wdata[0]);
                lgmr_pkg::CFG_USE_ABS:  r_use_abs  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // only a shot end needs room in the result register
    assign out_free = !o_valid || !i_stall;
    assign advance  = r_in_vld && (!r_in.end_shot || out_free);
    assign o_stall  = r_in_vld && !advance;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.fire     <= 1'b0;
            r_in.elem     <= i_element_valid;
            r_in.fault    <= i_fault_bit;
            r_in.corr     <= i_correction_bit;
            r_in.weight   <= i_weight;
            r_in.end_vec  <= i_last_in_vector;
            r_in.end_clu  <= i_last_in_cluster;
            r_in.end_shot <= i_last_in_shot;
        end
    end

    always_comb begin
        step      = r_in;
        step.fire = advance;
    end

    lgmr_vec u_vec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_gap_mode (r_gap_mode),
        .i_use_abs  (r_use_abs),
        .o_clu      (clu),
        .o_count    (count)
    );

    lgmr_shot u_shot (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_clu          (clu),
        .i_count        (count),
        .i_gap_mode     (r_gap_mode),
        .i_agg_mode     (r_agg_mode),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_gap          (o_gap),
        .o_gap_class    (o_gap_class),
        .o_vector_count (o_vector_count)
    );

endmodule

// File: hw/rtl/lgmr_checker.sv
module lgmr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [lgmr_pkg::TOTAL_W-1:0]  o_gap,
    input logic [1:0]                           o_gap_class,
    input logic [lgmr_pkg::COUNT_W-1:0]         o_vector_count
);

    // a stalled result stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_gap) && $stable(o_gap_class)
                               && $stable(o_vector_count))
        else $error("stalled result changed");

    // infinite gaps carry a zero value
    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gap_class != lgmr_pkg::CLASS_FINITE |-> o_gap == '0)
        else $error("infinite gap with nonzero value");

    // a finite gap needs at least one vector
    a_finite_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gap_class == lgmr_pkg::CLASS_FINITE |-> o_vector_count != '0)
        else $error("finite gap from a shot with no vectors");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind logical_gap_metric_reducer lgmr_checker u_lgmr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_gap          (o_gap),
    .o_gap_class    (o_gap_class),
    .o_vector_count (o_vector_count)
);

// File: tb/sv/logical_gap_metric_reducer_test.sv
`timescale 1ns / 1ps

module logical_gap_metric_reducer_test;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam longint SCORE_HI = lgmr_pkg::SCORE_MAX;
    localparam longint SCORE_LO = lgmr_pkg::SCORE_MIN;
    localparam longint TOTAL_HI = lgmr_pkg::TOTAL_MAX;
    localparam longint TOTAL_LO = lgmr_pkg::TOTAL_MIN;

    typedef struct {
        logic signed [lgmr_pkg::TOTAL_W-1:0] gap;
        logic [1:0]                          cls;
        logic [lgmr_pkg::COUNT_W-1:0]        count;
    } t_shot_result;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_we = 1'b0;
    logic [lgmr_pkg::CFG_IDX_W-1:0]        i_cfg_idx = lgmr_pkg::CFG_GAP_MODE;
    logic [lgmr_pkg::CFG_DATA_W-1:0]       i_cfg_wdata = '0;
    logic                                  i_valid = 1'b0;
    logic                                  o_stall;
    logic                                  i_element_valid = 1'b0;
    logic                                  i_fault_bit = 1'b0;
    logic                                  i_correction_bit = 1'b0;
    logic [lgmr_pkg::WEIGHT_W-1:0]         i_weight = '0;
    logic                                  i_last_in_vector = 1'b0;
    logic                                  i_last_in_cluster = 1'b0;
    logic                                  i_last_in_shot = 1'b0;
    logic                                  o_valid;
    logic                                  i_stall = 1'b0;
    logic signed [lgmr_pkg::TOTAL_W-1:0]   o_gap;
    logic [1:0]                            o_gap_class;
    logic [lgmr_pkg::COUNT_W-1:0]          o_vector_count;

    // shadow of the block's registers and accumulators
    lgmr_pkg::t_gap_mode gap_mode_q = lgmr_pkg::MODE_BINARY;
    lgmr_pkg::t_agg_mode agg_mode_q = lgmr_pkg::AGG_MIN;
    logic         use_abs_q = 1'b0;
    longint       open_score = 0;
    longint       cluster_min = 0;
    longint       shot_total = 0;
    bit           cluster_has_vec = 1'b0;
    bit           shot_has_cluster = 1'b0;
    int unsigned  shot_vectors = 0;

    t_shot_result pending_shots[$];
    t_shot_result want;

    int unsigned  error_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  items_sent = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct = 0;

    logical_gap_metric_reducer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_element_valid   (i_element_valid),
        .i_fault_bit       (i_fault_bit),
        .i_correction_bit  (i_correction_bit),
        .i_weight          (i_weight),
        .i_last_in_vector  (i_last_in_vector),
        .i_last_in_cluster (i_last_in_cluster),
        .i_last_in_shot    (i_last_in_shot),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_gap             (o_gap),
        .o_gap_class       (o_gap_class),
        .o_vector_count    (o_vector_count)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [lgmr_pkg::WEIGHT_W-1:0] rand_weight();
        unique case ($urandom_range(7))
            0: return '1;
            1: return '0;
            default: return lgmr_pkg::WEIGHT_W'($urandom);
        endcase
    endfunction

    // scores one accepted element and queues the shot result when the shot closes
    task automatic predict_element(input logic ev, input logic fb, input logic cb,
                                   input logic [lgmr_pkg::WEIGHT_W-1:0] w,
                                   input logic lv, input logic lc, input logic ls);
        longint       step;
        longint       s;
        t_shot_result r;
        if (ev) begin
            step = 0;
            if (fb) begin
                unique case (gap_mode_q)
                    lgmr_pkg::MODE_HAMMING: step = lgmr_pkg::ONE_FIXED;
                    lgmr_pkg::MODE_PRIOR:   step = longint'(w);
                    lgmr_pkg::MODE_WDIFF:   step = cb ? -longint'(w) : longint'(w);
                    default:                step = 0;
                endcase
            end
            open_score = clamp(open_score + step, SCORE_LO, SCORE_HI);
            if (lv || lc || ls) begin
                s = open_score;
                if (gap_mode_q == lgmr_pkg::MODE_WDIFF && use_abs_q && s < 0)
                    s = clamp(-s, SCORE_LO, SCORE_HI);
                if (!cluster_has_vec || s < cluster_min)
                    cluster_min = s;
                cluster_has_vec = 1'b1;
                if (shot_vectors < lgmr_pkg::COUNT_MAX)
                    shot_vectors++;
                open_score = 0;
            end
        end
        if ((lc || ls) && cluster_has_vec) begin
            if (!shot_has_cluster) begin
                shot_total = cluster_min;
            end else if (agg_mode_q == lgmr_pkg::AGG_MIN) begin
                if (cluster_min < shot_total)
                    shot_total = cluster_min;
            end else begin
                shot_total = clamp(shot_total + cluster_min, TOTAL_LO, TOTAL_HI);
            end
            shot_has_cluster = 1'b1;
            cluster_has_vec = 1'b0;
            cluster_min = 0;
        end
        if (ls) begin
            r.gap = '0;
            if (gap_mode_q == lgmr_pkg::MODE_BINARY) begin
                r.cls = shot_has_cluster ? lgmr_pkg::CLASS_MINUS_INF : lgmr_pkg::CLASS_PLUS_INF;
            end else if (!shot_has_cluster) begin
                r.cls = lgmr_pkg::CLASS_PLUS_INF;
            end else begin
                r.cls = lgmr_pkg::CLASS_FINITE;
                r.gap = shot_total[lgmr_pkg::TOTAL_W-1:0];
            end
            r.count = shot_vectors[lgmr_pkg::COUNT_W-1:0];
            pending_shots.insert(pending_shots.size(), r);
            open_score = 0;
            cluster_min = 0;
            cluster_has_vec = 1'b0;
            shot_total = 0;
            shot_has_cluster = 1'b0;
            shot_vectors = 0;
        end
    endtask

    // called and returns at a falling edge; valid stays high until the caller idles
    task automatic send_item(input logic ev, input logic fb, input logic cb,
                             input logic [lgmr_pkg::WEIGHT_W-1:0] w,
                             input logic lv, input logic lc, input logic ls);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_element_valid = ev;
        i_fault_bit = fb;
        i_correction_bit = cb;
        i_weight = w;
        i_last_in_vector = lv;
        i_last_in_cluster = lc;
        i_last_in_shot = ls;
        do @(posedge i_clk); while (o_stall);
        predict_element(ev, fb, cb, w, lv, lc, ls);
        items_sent++;
        @(negedge i_clk);
    endtask

    // drop valid and let every expected result and any in-flight element drain
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending_shots.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lgmr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lgmr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        unique case (idx)
            lgmr_pkg::CFG_GAP_MODE: gap_mode_q = lgmr_pkg::t_gap_mode'(data);
            lgmr_pkg::CFG_AGG_MODE: agg_mode_q = lgmr_pkg::t_agg_mode'(data[0]);
            lgmr_pkg::CFG_USE_ABS:  use_abs_q = data[0];
            default: ;
        endcase
    endtask

    task automatic set_modes(input lgmr_pkg::t_gap_mode g, input lgmr_pkg::t_agg_mode a,
                             input logic abs_on);
        wait_idle();
        write_reg(lgmr_pkg::CFG_GAP_MODE, g);
        write_reg(lgmr_pkg::CFG_AGG_MODE, {1'b0, a});
        write_reg(lgmr_pkg::CFG_USE_ABS, {1'b0, abs_on});
    endtask

    task automatic test_binary_mode();
        set_modes(lgmr_pkg::MODE_BINARY, lgmr_pkg::AGG_MIN, 1'b0);
        send_item(1, 1, 1, 16'hFFFF, 1, 0, 1);
        send_item(0, 0, 0, 16'h0000, 0, 0, 1);
    endtask

    task automatic test_hamming_minimum();
        set_modes(lgmr_pkg::MODE_HAMMING, lgmr_pkg::AGG_MIN, 1'b0);
        send_item(1, 1, 0, 16'h1234, 0, 0, 0);
        send_item(1, 1, 1, 16'h0000, 1, 0, 0);
        send_item(1, 0, 0, 16'hFFFF, 0, 1, 0);
        send_item(1, 1, 0, 16'h00FF, 0, 0, 1);
    endtask

    task automatic test_prior_sum();
        set_modes(lgmr_pkg::MODE_PRIOR, lgmr_pkg::AGG_SUM, 1'b0);
        send_item(1, 1, 1, 16'hFFFF, 0, 1, 0);
        send_item(1, 1, 0, 16'h0000, 1, 0, 0);
        send_item(1, 1, 0, 16'd1234, 0, 1, 0);
        send_item(0, 1, 1, 16'hFFFF, 1, 1, 1);
    endtask

    task automatic test_weight_difference();
        set_modes(lgmr_pkg::MODE_WDIFF, lgmr_pkg::AGG_MIN, 1'b0);
        send_item(1, 1, 1, 16'd300, 0, 0, 0);
        send_item(1, 1, 0, 16'd100, 1, 0, 0);
        send_item(1, 1, 0, 16'd50, 0, 0, 1);
        set_modes(lgmr_pkg::MODE_WDIFF, lgmr_pkg::AGG_SUM, 1'b1);
        send_item(1, 1, 1, 16'd300, 0, 0, 0);
        send_item(1, 0, 1, 16'hFFFF, 0, 1, 0);
        send_item(1, 1, 0, 16'd50, 0, 0, 1);
    endtask

    task automatic test_marks_and_markers();
        set_modes(lgmr_pkg::MODE_HAMMING, lgmr_pkg::AGG_SUM, 1'b0);
        send_item(0, 1, 1, 16'hFFFF, 0, 1, 0);  // cluster with no vectors
        send_item(1, 1, 0, 16'h0000, 0, 0, 0);
        send_item(0, 1, 0, 16'h0000, 1, 0, 0);  // marker cannot close a vector
        send_item(1, 1, 0, 16'h0000, 0, 1, 0);
        send_item(0, 0, 0, 16'h0000, 0, 1, 0);
        send_item(1, 1, 1, 16'h0000, 0, 0, 0);  // left open, dropped at shot end
        send_item(0, 0, 0, 16'h0000, 0, 0, 1);
    endtask

    task automatic test_mode_change_mid_shot();
        set_modes(lgmr_pkg::MODE_HAMMING, lgmr_pkg::AGG_MIN, 1'b0);
        send_item(1, 1, 0, 16'h0010, 0, 0, 0);
        send_item(1, 1, 1, 16'h0010, 1, 0, 0);
        wait_idle();
        write_reg(lgmr_pkg::CFG_GAP_MODE, lgmr_pkg::MODE_PRIOR);
        send_item(1, 1, 1, 16'd1000, 0, 1, 0);
        wait_idle();
        write_reg(lgmr_pkg::CFG_AGG_MODE, {1'b0, lgmr_pkg::AGG_SUM});
        send_item(1, 1, 0, 16'd7, 0, 0, 1);
        send_item(1, 1, 0, 16'd9, 1, 0, 0);
        wait_idle();
        write_reg(lgmr_pkg::CFG_GAP_MODE, lgmr_pkg::MODE_BINARY);
        send_item(0, 0, 0, 16'h0000, 0, 0, 1);
    endtask

    // well-formed shot with random shape and content, sprinkled with stray transactions
    task automatic send_random_shot();
        int unsigned n_clusters;
        int unsigned n_vectors;
        int unsigned n_elems;
        int unsigned close_style;
        bit          shot_closed;
        bit          last_elem;
        bit          last_vec;
        shot_closed = 1'b0;
        n_clusters = $urandom_range(0, 3);
        for (int c = 0; c < n_clusters; c++) begin
            n_vectors = $urandom_range(0, 3);
            if (n_vectors == 0)
                send_item(0, rand_bit(), rand_bit(), rand_weight(), rand_bit(), 1, 0);
            for (int v = 0; v < n_vectors; v++) begin
                n_elems = $urandom_range(1, 4);
                last_vec = (v == n_vectors - 1);
                for (int k = 0; k < n_elems; k++) begin
                    if ($urandom_range(9) == 0)
                        send_item(rand_bit(), rand_bit(), rand_bit(), rand_weight(),
                                  rand_bit(), rand_bit(), $urandom_range(15) == 0);
                    last_elem = (k == n_elems - 1);
                    close_style = $urandom_range(3);
                    if (last_elem && last_vec && c == n_clusters - 1 && close_style == 3) begin
                        send_item(1, rand_bit(), rand_bit(), rand_weight(),
                                  rand_bit(), rand_bit(), 1);
                        shot_closed = 1'b1;
                    end else if (last_elem && last_vec && close_style != 0) begin
                        send_item(1, rand_bit(), rand_bit(), rand_weight(),
                                  close_style == 2, 1, 0);
                    end else begin
                        send_item(1, rand_bit(), rand_bit(), rand_weight(),
                                  last_elem, 0, 0);
                        if (last_elem && last_vec)
                            send_item(0, rand_bit(), rand_bit(), rand_weight(),
                                      rand_bit(), 1, 0);
                    end
                end
            end
        end
        if (!shot_closed) begin
            if ($urandom_range(7) == 0)
                send_item(1, rand_bit(), rand_bit(), rand_weight(), 0, 0, 0);
            send_item(0, rand_bit(), rand_bit(), rand_weight(), rand_bit(), rand_bit(), 1);
        end
        if ($urandom_range(9) == 0)
            wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned send_pcts[4];
        int unsigned stall_pcts[4];
        int unsigned target;
        send_pcts = '{0, 70, 0, 26};
        stall_pcts = '{0, 0, 70, 26};
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 2; k++) begin
                set_modes(lgmr_pkg::t_gap_mode'((2 * p + k) % 4),
                          lgmr_pkg::t_agg_mode'(rand_bit()), rand_bit());
                send_idle_pct = send_pcts[p];
                stall_pct = stall_pcts[p];
                target = items_sent + 70;
                while (items_sent < target)
                    send_random_shot();
            end
        end
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_shots.size() == 0) begin
                $display("%0t: unexpected result transaction, gap %0d class %0d count %0d",
                         $time, o_gap, o_gap_class, o_vector_count);
                error_count++;
            end else begin
                want = pending_shots.pop_front();
                if (o_gap !== want.gap) begin
                    $display("%0t: gap mismatch, expected %0d, actual %0d",
                             $time, want.gap, o_gap);
                    error_count++;
                end
                if (o_gap_class !== want.cls) begin
                    $display("%0t: gap_class mismatch, expected %0d, actual %0d",
                             $time, want.cls, o_gap_class);
                    error_count++;
                end
                if (o_vector_count !== want.count) begin
                    $display("%0t: vector_count mismatch, expected %0d, actual %0d",
                             $time, want.count, o_vector_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_shots.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_binary_mode();
        test_hamming_minimum();
        test_prior_sum();
        test_weight_difference();
        test_marks_and_markers();
        test_mode_change_mid_shot();
        test_random_traffic();
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && pending_shots.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lgmr_pkg.sv
hw/rtl/lgmr_vec.sv
hw/rtl/lgmr_shot.sv
hw/rtl/logical_gap_metric_reducer.sv
hw/rtl/lgmr_checker.sv
tb/sv/logical_gap_metric_reducer_test.sv
